// ===== rtl/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cee_pkg: shared types and constants of the I2C EEPROM master
// Sequencer phases, byte stages, operation and status codes, state and
// result records passed between the step logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

  localparam int unsigned HalfW   = 16;
  localparam int unsigned DevW    = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned StatW   = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [HalfW-1:0] HalfReset = 16'd840;
  localparam logic [DevW-1:0]  DevReset  = 7'd80;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDevAddr    = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_LOAD  = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START_A   = 5'd1,
    PH_START_B   = 5'd2,
    PH_START_C   = 5'd3,
    PH_TX_LOW    = 5'd4,
    PH_TX_HIGH   = 5'd5,
    PH_ACK_LOW   = 5'd6,
    PH_ACK_HIGH  = 5'd7,
    PH_RX_LOW    = 5'd8,
    PH_RX_HIGH   = 5'd9,
    PH_MACK_LOW  = 5'd10,
    PH_MACK_HIGH = 5'd11,
    PH_WAIT_DATA = 5'd12,
    PH_RS_A      = 5'd13,
    PH_STOP_A    = 5'd14,
    PH_STOP_B    = 5'd15,
    PH_STOP_C    = 5'd16
  } phase_e;

  typedef enum logic [2:0] {
    STG_DEV_W = 3'd0,
    STG_WORD  = 3'd1,
    STG_DEV_R = 3'd2,
    STG_WDATA = 3'd3,
    STG_RDATA = 3'd4
  } stage_e;

  localparam logic [StatW-1:0] StatOk       = 3'd0;
  localparam logic [StatW-1:0] StatDevNack  = 3'd1;
  localparam logic [StatW-1:0] StatWordNack = 3'd2;
  localparam logic [StatW-1:0] StatRdNack   = 3'd3;
  localparam logic [StatW-1:0] StatDataNack = 3'd4;

  typedef struct packed {
    phase_e              phase;
    logic [HalfW-1:0]    tick_count;
    logic [BitIdxW-1:0]  bit_index;
    logic [ByteW-1:0]    shift_byte;
    logic [ByteW-1:0]    bytes_left;
    logic [ByteW-1:0]    saved_word_address;
    logic                is_read;
    stage_e              stage;
    logic [StatW-1:0]    status;
  } seq_state_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic             done_res;
    logic             busy_res;
    logic             data_request;
    logic             read_valid;
    logic [ByteW-1:0] read_data;
    logic             sda_release;
    logic             scl;
  } result_t;

  localparam int unsigned ResW  = $bits(result_t);
  localparam int unsigned OutTW = ((ResW + 7) / 8) * 8;
  localparam int unsigned InW   = 3 * ByteW + 1;
  localparam int unsigned InTW  = ((InW + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== rtl/i2cee_step.sv =====
// ----------------------------------------------------------------------------
// i2cee_step: one tick of the I2C bit sequencer
// Takes the current sequencer state and one input word, and gives the next
// state plus the bus levels and flags for this tick. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_step (
  input  i2cee_pkg::seq_state_t               state_i,
  input  logic [i2cee_pkg::HalfW-1:0]         half_period_i,
  input  logic [i2cee_pkg::DevW-1:0]          dev_addr_i,
  input  i2cee_pkg::op_e                      op_i,
  input  logic [i2cee_pkg::ByteW-1:0]         word_address_i,
  input  logic [i2cee_pkg::ByteW-1:0]         byte_count_i,
  input  logic [i2cee_pkg::ByteW-1:0]         write_data_i,
  input  logic                                sda_level_i,
  output i2cee_pkg::seq_state_t               state_o,
  output i2cee_pkg::result_t                  result_o
);

  always_comb begin
    i2cee_pkg::seq_state_t s;
    i2cee_pkg::phase_e     ph;
    logic                  bit_v;
    logic                  scl;
    logic                  sda;
    logic                  rvalid;
    logic [i2cee_pkg::ByteW-1:0] rdata;
    logic                  done;
    logic [i2cee_pkg::HalfW:0]   tick_inc;
    logic [i2cee_pkg::ByteW-1:0] bl_dec;
    logic [i2cee_pkg::ByteW-1:0] shifted;

    s      = state_i;
    bit_v  = state_i.shift_byte[state_i.bit_index];
    rvalid = 1'b0;
    rdata  = '0;
    done   = 1'b0;

    // take a begin while idle, or a data word while waiting for one
    if (state_i.phase == i2cee_pkg::PH_IDLE &&
        (op_i == i2cee_pkg::OP_WRITE || op_i == i2cee_pkg::OP_READ)) begin
      s.saved_word_address = word_address_i;
      s.bytes_left         = byte_count_i;
      s.is_read            = (op_i == i2cee_pkg::OP_READ);
      s.stage              = i2cee_pkg::STG_DEV_W;
      s.phase              = i2cee_pkg::PH_START_A;
      s.tick_count         = '0;
    end else if (state_i.phase == i2cee_pkg::PH_WAIT_DATA &&
                 op_i == i2cee_pkg::OP_LOAD) begin
      s.shift_byte = write_data_i;
      s.bit_index  = '1;
      s.phase      = i2cee_pkg::PH_TX_LOW;
      s.tick_count = '0;
      bit_v        = write_data_i[i2cee_pkg::ByteW-1];
    end

    ph = s.phase;

    // bus levels for this tick
    case (ph)
      i2cee_pkg::PH_START_A:   begin scl = 1'b1; sda = 1'b1; end
      i2cee_pkg::PH_START_B:   begin scl = 1'b1; sda = 1'b0; end
      i2cee_pkg::PH_START_C:   begin scl = 1'b0; sda = 1'b0; end
      i2cee_pkg::PH_TX_LOW:    begin scl = 1'b0; sda = bit_v; end
      i2cee_pkg::PH_TX_HIGH:   begin scl = 1'b1; sda = bit_v; end
      i2cee_pkg::PH_ACK_LOW,
      i2cee_pkg::PH_RX_LOW:    begin scl = 1'b0; sda = 1'b1; end
      i2cee_pkg::PH_ACK_HIGH,
      i2cee_pkg::PH_RX_HIGH:   begin scl = 1'b1; sda = 1'b1; end
      i2cee_pkg::PH_MACK_LOW:  begin scl = 1'b0; sda = (s.bytes_left == '0); end
      i2cee_pkg::PH_MACK_HIGH: begin scl = 1'b1; sda = (s.bytes_left == '0); end
      i2cee_pkg::PH_WAIT_DATA: begin scl = 1'b0; sda = 1'b0; end
      i2cee_pkg::PH_RS_A:      begin scl = 1'b0; sda = 1'b1; end
      i2cee_pkg::PH_STOP_A:    begin scl = 1'b0; sda = 1'b0; end
      i2cee_pkg::PH_STOP_B:    begin scl = 1'b1; sda = 1'b0; end
      i2cee_pkg::PH_STOP_C:    begin scl = 1'b1; sda = 1'b1; end
      default:                 begin scl = 1'b1; sda = 1'b1; end
    endcase

    tick_inc = {1'b0, s.tick_count} + 1'b1;
    bl_dec   = s.bytes_left - 1'b1;
    shifted  = {s.shift_byte[i2cee_pkg::ByteW-2:0], sda_level_i};

    // advance the half-period timer, then the phase at its end
    if (ph != i2cee_pkg::PH_IDLE && ph != i2cee_pkg::PH_WAIT_DATA) begin
      if (tick_inc < {1'b0, half_period_i}) begin
        s.tick_count = tick_inc[i2cee_pkg::HalfW-1:0];
      end else begin
        s.tick_count = '0;
        case (ph)
          i2cee_pkg::PH_START_A: s.phase = i2cee_pkg::PH_START_B;
          i2cee_pkg::PH_START_B: s.phase = i2cee_pkg::PH_START_C;
          i2cee_pkg::PH_START_C: begin
            s.shift_byte = {dev_addr_i, (s.stage == i2cee_pkg::STG_DEV_R)};
            s.bit_index  = '1;
            s.phase      = i2cee_pkg::PH_TX_LOW;
          end
          i2cee_pkg::PH_TX_LOW:  s.phase = i2cee_pkg::PH_TX_HIGH;
          i2cee_pkg::PH_TX_HIGH: begin
            if (s.bit_index == '0) begin
              s.phase = i2cee_pkg::PH_ACK_LOW;
            end else begin
              s.bit_index = s.bit_index - 1'b1;
              s.phase     = i2cee_pkg::PH_TX_LOW;
            end
          end
          i2cee_pkg::PH_ACK_LOW: s.phase = i2cee_pkg::PH_ACK_HIGH;
          i2cee_pkg::PH_ACK_HIGH: begin
            if (sda_level_i) begin
              // nack: stop with the code of the byte that failed
              case (s.stage)
                i2cee_pkg::STG_DEV_W: s.status = i2cee_pkg::StatDevNack;
                i2cee_pkg::STG_WORD:  s.status = i2cee_pkg::StatWordNack;
                i2cee_pkg::STG_DEV_R: s.status = i2cee_pkg::StatRdNack;
                default:              s.status = i2cee_pkg::StatDataNack;
              endcase
              s.phase = i2cee_pkg::PH_STOP_A;
            end else begin
              case (s.stage)
                i2cee_pkg::STG_DEV_W: begin
                  s.stage      = i2cee_pkg::STG_WORD;
                  s.shift_byte = s.saved_word_address;
                  s.bit_index  = '1;
                  s.phase      = i2cee_pkg::PH_TX_LOW;
                end
                i2cee_pkg::STG_WORD: begin
                  if (s.bytes_left == '0) begin
                    s.status = i2cee_pkg::StatOk;
                    s.phase  = i2cee_pkg::PH_STOP_A;
                  end else if (s.is_read) begin
                    s.stage = i2cee_pkg::STG_DEV_R;
                    s.phase = i2cee_pkg::PH_RS_A;
                  end else begin
                    s.stage = i2cee_pkg::STG_WDATA;
                    s.phase = i2cee_pkg::PH_WAIT_DATA;
                  end
                end
                i2cee_pkg::STG_DEV_R: begin
                  s.stage      = i2cee_pkg::STG_RDATA;
                  s.shift_byte = '0;
                  s.bit_index  = '1;
                  s.phase      = i2cee_pkg::PH_RX_LOW;
                end
                default: begin
                  s.bytes_left = bl_dec;
                  if (bl_dec == '0) begin
                    s.status = i2cee_pkg::StatOk;
                    s.phase  = i2cee_pkg::PH_STOP_A;
                  end else begin
                    s.phase = i2cee_pkg::PH_WAIT_DATA;
                  end
                end
              endcase
            end
          end
          i2cee_pkg::PH_RX_LOW: s.phase = i2cee_pkg::PH_RX_HIGH;
          i2cee_pkg::PH_RX_HIGH: begin
            s.shift_byte = shifted;
            if (s.bit_index == '0) begin
              rvalid       = 1'b1;
              rdata        = shifted;
              s.bytes_left = bl_dec;
              s.phase      = i2cee_pkg::PH_MACK_LOW;
            end else begin
              s.bit_index = s.bit_index - 1'b1;
              s.phase     = i2cee_pkg::PH_RX_LOW;
            end
          end
          i2cee_pkg::PH_MACK_LOW: s.phase = i2cee_pkg::PH_MACK_HIGH;
          i2cee_pkg::PH_MACK_HIGH: begin
            if (s.bytes_left == '0) begin
              s.status = i2cee_pkg::StatOk;
              s.phase  = i2cee_pkg::PH_STOP_A;
            end else begin
              s.shift_byte = '0;
              s.bit_index  = '1;
              s.phase      = i2cee_pkg::PH_RX_LOW;
            end
          end
          i2cee_pkg::PH_RS_A:   s.phase = i2cee_pkg::PH_START_A;
          i2cee_pkg::PH_STOP_A: s.phase = i2cee_pkg::PH_STOP_B;
          i2cee_pkg::PH_STOP_B: s.phase = i2cee_pkg::PH_STOP_C;
          i2cee_pkg::PH_STOP_C: begin
            s.phase = i2cee_pkg::PH_IDLE;
            done    = 1'b1;
          end
          default: s.phase = i2cee_pkg::PH_IDLE;
        endcase
      end
    end

    state_o = s;

    result_o.scl          = scl;
    result_o.sda_release  = sda;
    result_o.read_data    = rdata;
    result_o.read_valid   = rvalid;
    result_o.data_request = (s.phase == i2cee_pkg::PH_WAIT_DATA);
    result_o.busy_res     = (s.phase != i2cee_pkg::PH_IDLE);
    result_o.done_res     = done;
    result_o.status       = s.status;
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_eeprom_master.sv =====
// ----------------------------------------------------------------------------
// i2c_eeprom_master: bit-level I2C master for a small serial EEPROM
// Runs start, device address, word address, then write bytes or a repeated
// start and read bytes, then stop. One input word is one timing tick.
//
//   channel   dir  fields
//   s_axis    in   tuser: operation; tdata: word_address, byte_count,
//                  write_data, sda_level
//   m_axis    out  tdata: scl, sda_release, read_data, read_valid,
//                  data_request, busy_res, done_res, status
//   cfg       in   index 0 half_period_ticks, index 1 device_address
//
// One word per cycle: the step logic updates the sequencer state on the
// accepting edge and the result word lands in the output register.
// The output register frees on the same edge it is taken, so input and
// output may both move every cycle; a stalled output holds the input back.
// Reset clears the sequencer to idle and loads the default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_master (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [i2cee_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [i2cee_pkg::HalfW-1:0]         cfg_data_i,
  // tick words in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] word_address, [15:8] byte_count, [23:16] write_data,
  // [24] sda_level, [31:25] zero
  input  logic [i2cee_pkg::InTW-1:0]          s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]                          s_axis_tuser,
  // result words out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] scl, [1] sda_release, [9:2] read_data, [10] read_valid,
  // [11] data_request, [12] busy_res, [13] done_res, [16:14] status,
  // [23:17] zero
  output logic [i2cee_pkg::OutTW-1:0]         m_axis_tdata
);

  localparam int unsigned BW = i2cee_pkg::ByteW;

  logic [i2cee_pkg::HalfW-1:0] half_q;
  logic [i2cee_pkg::DevW-1:0]  dev_q;
  i2cee_pkg::seq_state_t       state_q;
  i2cee_pkg::seq_state_t       state_d;
  i2cee_pkg::result_t          res_d;
  i2cee_pkg::result_t          res_q;
  logic                        out_valid_q;
  logic                        accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= i2cee_pkg::HalfReset;
      dev_q  <= i2cee_pkg::DevReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cee_pkg::CfgHalfPeriod: half_q <= cfg_data_i;
        i2cee_pkg::CfgDevAddr:    dev_q  <= cfg_data_i[i2cee_pkg::DevW-1:0];
        default: ;
      endcase
    end
  end

  i2cee_step u_step (
    .state_i        (state_q),
    .half_period_i  (half_q),
    .dev_addr_i     (dev_q),
    .op_i           (i2cee_pkg::op_e'(s_axis_tuser)),
    .word_address_i (s_axis_tdata[BW-1:0]),
    .byte_count_i   (s_axis_tdata[2*BW-1:BW]),
    .write_data_i   (s_axis_tdata[3*BW-1:2*BW]),
    .sda_level_i    (s_axis_tdata[3*BW]),
    .state_o        (state_d),
    .result_o       (res_d)
  );

  // advance the sequencer on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: i2cee_pkg::PH_IDLE, stage: i2cee_pkg::STG_DEV_W,
                   default: '0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(i2cee_pkg::OutTW - i2cee_pkg::ResW){1'b0}}, res_q};

endmodule

`default_nettype wire

// ===== rtl/i2cee_checker.sv =====
// ----------------------------------------------------------------------------
// i2cee_checker: port-level checks on the I2C EEPROM master
// Watches the result stream for consistent flags and a held stalled word.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cee_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [i2cee_pkg::OutTW-1:0]         m_axis_tdata
);

  logic scl, rvalid, dreq, busy, done;

  assign scl    = m_axis_tdata[0];
  assign rvalid = m_axis_tdata[10];
  assign dreq   = m_axis_tdata[11];
  assign busy   = m_axis_tdata[12];
  assign done   = m_axis_tdata[13];

  // hold a stalled result word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // a finished transfer leaves the master idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && done |-> !busy && !dreq)
    else $error("done while still busy");

  // a data request only comes mid-transfer
  a_dreq_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && dreq |-> busy && !done)
    else $error("data request outside a transfer");

  // a received byte completes with SCL high and the acknowledge still ahead
  a_rx_scl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && rvalid |-> scl && busy)
    else $error("read byte outside SCL high");

endmodule

bind i2c_eeprom_master i2cee_checker u_i2cee_checker (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the I2C EEPROM master
// Drives one tick word per handshake and answers the bus like a small
// EEPROM: ACK or forced NACK in the acknowledge slots, random bits while the
// master reads. A bus model in the bench predicts every result word, and each
// received word is checked field by field against it. A short table of
// directed transfers runs first, then random transfers with idle gaps on
// both sides, one long output hold-off and several timing and address
// settings.
// ----------------------------------------------------------------------------

module testbench;
  import i2cee_pkg::*;

  // device answers every acknowledge slot with ACK
  localparam int AckAll   = -1;
  localparam int NumItems = 900;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] waddr;
    logic [ByteW-1:0] nbytes;
    logic [ByteW-1:0] wdata;
    logic             sda;
  } tick_t;

  typedef enum {ROW_WORD, ROW_XFER, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    op_e                op;
    logic [ByteW-1:0]   wa;
    logic [ByteW-1:0]   cnt;
    logic [ByteW-1:0]   wd;
    logic               sda;
    int                 nack_at;
    bit                 noisy;
    bit                 typed;
    logic [StatW-1:0]   want_stat;
    logic [CfgIdxW-1:0] cfg_idx;
    logic [HalfW-1:0]   cfg_val;
  } row_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [HalfW-1:0]   cfg_data_i    = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InTW-1:0]    s_axis_tdata  = '0;
  logic [1:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutTW-1:0]   m_axis_tdata;

  // bus model state and its copy of the registers
  logic [HalfW-1:0] cfg_half  = HalfReset;
  logic [DevW-1:0]  cfg_dev   = DevReset;
  phase_e           bus_ph    = PH_IDLE;
  logic [HalfW-1:0] bus_tick  = '0;
  logic [2:0]       bus_bit   = '0;
  logic [ByteW-1:0] bus_shift = '0;
  logic [ByteW-1:0] bus_left  = '0;
  logic [ByteW-1:0] bus_waddr = '0;
  logic             bus_rd    = 1'b0;
  stage_e           bus_stg   = STG_DEV_W;
  logic [StatW-1:0] bus_stat  = StatOk;

  result_t bus_expect_q[$];
  int      n_sent     = 0;
  int      n_taken    = 0;
  int      n_mismatch = 0;
  int      hold_left  = 0;
  bit      hold_done  = 1'b0;

  i2c_eeprom_master u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- bus model

  function automatic void load_byte(input logic [ByteW-1:0] v);
    bus_shift = v;
    bus_bit   = 3'd7;
    bus_ph    = PH_TX_LOW;
  endfunction

  function automatic void finish_with(input logic [StatW-1:0] code);
    bus_stat = code;
    bus_ph   = PH_STOP_A;
  endfunction

  // advance the bus model by one tick word and return the result word
  function automatic result_t bus_step(input tick_t w);
    result_t r;
    logic    b;
    r             = '0;
    r.scl         = 1'b1;
    r.sda_release = 1'b1;
    b             = bus_shift[bus_bit];

    // take a begin only when idle, a load only while waiting for data
    if (bus_ph == PH_IDLE && (w.op == OP_WRITE || w.op == OP_READ)) begin
      bus_waddr = w.waddr;
      bus_left  = w.nbytes;
      bus_rd    = (w.op == OP_READ);
      bus_stg   = STG_DEV_W;
      bus_ph    = PH_START_A;
      bus_tick  = '0;
    end else if (bus_ph == PH_WAIT_DATA && w.op == OP_LOAD) begin
      load_byte(w.wdata);
      bus_tick = '0;
      b        = w.wdata[7];
    end

    // line levels for this tick
    case (bus_ph)
      PH_START_B, PH_STOP_B: r.sda_release = 1'b0;
      PH_START_C, PH_WAIT_DATA, PH_STOP_A: begin
        r.scl         = 1'b0;
        r.sda_release = 1'b0;
      end
      PH_TX_LOW: begin
        r.scl         = 1'b0;
        r.sda_release = b;
      end
      PH_TX_HIGH: r.sda_release = b;
      PH_ACK_LOW, PH_RX_LOW, PH_RS_A: r.scl = 1'b0;
      PH_MACK_LOW: begin
        r.scl         = 1'b0;
        r.sda_release = (bus_left == 0);
      end
      PH_MACK_HIGH: r.sda_release = (bus_left == 0);
      default: ;
    endcase

    // count the half period, step the sequence at its last tick
    if (bus_ph != PH_IDLE && bus_ph != PH_WAIT_DATA) begin
      if (32'(bus_tick) + 1 < 32'(cfg_half)) begin
        bus_tick = bus_tick + 1'b1;
      end else begin
        bus_tick = '0;
        case (bus_ph)
          PH_START_A: bus_ph = PH_START_B;
          PH_START_B: bus_ph = PH_START_C;
          PH_START_C: load_byte({cfg_dev, bus_stg == STG_DEV_R});
          PH_TX_LOW:  bus_ph = PH_TX_HIGH;
          PH_TX_HIGH: begin
            if (bus_bit == 0) begin
              bus_ph = PH_ACK_LOW;
            end else begin
              bus_bit = bus_bit - 1'b1;
              bus_ph  = PH_TX_LOW;
            end
          end
          PH_ACK_LOW: bus_ph = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            if (w.sda) begin
              case (bus_stg)
                STG_DEV_W: finish_with(StatDevNack);
                STG_WORD:  finish_with(StatWordNack);
                STG_DEV_R: finish_with(StatRdNack);
                default:   finish_with(StatDataNack);
              endcase
            end else begin
              case (bus_stg)
                STG_DEV_W: begin
                  bus_stg = STG_WORD;
                  load_byte(bus_waddr);
                end
                STG_WORD: begin
                  if (bus_left == 0) begin
                    finish_with(StatOk);
                  end else if (bus_rd) begin
                    bus_stg = STG_DEV_R;
                    bus_ph  = PH_RS_A;
                  end else begin
                    bus_stg = STG_WDATA;
                    bus_ph  = PH_WAIT_DATA;
                  end
                end
                STG_DEV_R: begin
                  bus_stg   = STG_RDATA;
                  bus_shift = '0;
                  bus_bit   = 3'd7;
                  bus_ph    = PH_RX_LOW;
                end
                default: begin
                  bus_left = bus_left - 1'b1;
                  if (bus_left == 0) finish_with(StatOk);
                  else bus_ph = PH_WAIT_DATA;
                end
              endcase
            end
          end
          PH_RX_LOW: bus_ph = PH_RX_HIGH;
          PH_RX_HIGH: begin
            bus_shift = {bus_shift[ByteW-2:0], w.sda};
            if (bus_bit == 0) begin
              r.read_valid = 1'b1;
              r.read_data  = bus_shift;
              bus_left     = bus_left - 1'b1;
              bus_ph       = PH_MACK_LOW;
            end else begin
              bus_bit = bus_bit - 1'b1;
              bus_ph  = PH_RX_LOW;
            end
          end
          PH_MACK_LOW: bus_ph = PH_MACK_HIGH;
          PH_MACK_HIGH: begin
            if (bus_left == 0) begin
              finish_with(StatOk);
            end else begin
              bus_shift = '0;
              bus_bit   = 3'd7;
              bus_ph    = PH_RX_LOW;
            end
          end
          PH_RS_A:   bus_ph = PH_START_A;
          PH_STOP_A: bus_ph = PH_STOP_B;
          PH_STOP_B: bus_ph = PH_STOP_C;
          PH_STOP_C: begin
            bus_ph     = PH_IDLE;
            r.done_res = 1'b1;
          end
          default: bus_ph = PH_IDLE;
        endcase
      end
    end

    r.data_request = (bus_ph == PH_WAIT_DATA);
    r.busy_res     = (bus_ph != PH_IDLE);
    r.status       = bus_stat;
    return r;
  endfunction

  // result word of an idle master holding the given status
  function automatic result_t idle_word(input logic [StatW-1:0] stat);
    result_t r;
    r             = '0;
    r.scl         = 1'b1;
    r.sda_release = 1'b1;
    r.status      = stat;
    return r;
  endfunction

  function automatic string show_word(input result_t r);
    return $sformatf("scl %b sda %b rdata %02h rvalid %b dreq %b busy %b done %b status %0d",
                     r.scl, r.sda_release, r.read_data, r.read_valid, r.data_request,
                     r.busy_res, r.done_res, r.status);
  endfunction

  // ----------------------------------------------------------------- sender

  // offer one tick word, hold it until taken, then predict its result
  task automatic offer_word(input tick_t w, input bit typed, input result_t want);
    bit      quiet;
    result_t r;
    quiet = (n_sent >= 500 && n_sent < 700);
    while (!quiet && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InTW - 25){1'b0}}, w.sda, w.wdata, w.nbytes, w.waddr};
    s_axis_tuser  <= w.op;
    do @(posedge clk_i); while (!s_axis_tready);
    r = bus_step(w);
    n_sent++;
    bus_expect_q.push_back(typed ? want : r);
  endtask

  // drop valid and wait until every result word is back
  task automatic drain_bus();
    s_axis_tvalid <= 1'b0;
    while (bus_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [HalfW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgHalfPeriod) cfg_half = val;
    else cfg_dev = val[DevW-1:0];
  endtask

  // run one transfer to its stop, answering the bus like the EEPROM
  task automatic run_transfer(input op_e op, input logic [ByteW-1:0] wa, cnt, wd,
                              input int nack_at, input bit noisy, input bit fresh);
    tick_t w;
    w = '{op, wa, cnt, wd, 1'($urandom_range(1))};
    offer_word(w, 1'b0, '0);
    while (bus_ph != PH_IDLE) begin
      w.op     = OP_TICK;
      w.waddr  = 8'($urandom);
      w.nbytes = 8'($urandom);
      w.sda    = 1'($urandom_range(1));
      if (bus_ph == PH_ACK_LOW || bus_ph == PH_ACK_HIGH)
        w.sda = (int'(bus_stg) == nack_at);
      if (bus_ph == PH_WAIT_DATA) begin
        // noisy runs keep the master waiting for a while
        if (!(noisy && $urandom_range(3) == 0)) w.op = OP_LOAD;
        w.wdata = fresh ? 8'($urandom) : wd;
      end else if (noisy && $urandom_range(7) == 0) begin
        w.op = op_e'($urandom_range(3));
      end
      offer_word(w, 1'b0, '0);
    end
  endtask

  function automatic row_t row_word(input op_e op, input logic [ByteW-1:0] wa, cnt, wd,
                                    input logic sda, input logic [StatW-1:0] stat);
    row_t r;
    r.kind      = ROW_WORD;
    r.op        = op;
    r.wa        = wa;
    r.cnt       = cnt;
    r.wd        = wd;
    r.sda       = sda;
    r.typed     = 1'b1;
    r.want_stat = stat;
    return r;
  endfunction

  function automatic row_t row_xfer(input op_e op, input logic [ByteW-1:0] wa, cnt, wd,
                                    input int nack_at, input bit noisy);
    row_t r;
    r.kind    = ROW_XFER;
    r.op      = op;
    r.wa      = wa;
    r.cnt     = cnt;
    r.wd      = wd;
    r.nack_at = nack_at;
    r.noisy   = noisy;
    return r;
  endfunction

  function automatic row_t row_cfg(input logic [CfgIdxW-1:0] idx, input logic [HalfW-1:0] val);
    row_t r;
    r.kind    = ROW_CFG;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // main sequence
  initial begin
    row_t  plan[$];
    tick_t w;
    int    xfers;
    int    nack;
    int    cnt;

    // idle words after reset, then every transfer kind and every nack
    plan.push_back(row_word(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, StatOk));
    plan.push_back(row_word(OP_LOAD, 8'hff, 8'hff, 8'hff, 1'b1, StatOk));
    plan.push_back(row_cfg(CfgHalfPeriod, 16'd1));
    plan.push_back(row_cfg(CfgDevAddr, 16'd127));
    plan.push_back(row_xfer(OP_WRITE, 8'hff, 8'd1, 8'hff, AckAll, 1'b0));
    plan.push_back(row_xfer(OP_READ, 8'h00, 8'd2, 8'h00, AckAll, 1'b0));
    plan.push_back(row_xfer(OP_WRITE, 8'h5a, 8'd0, 8'h00, AckAll, 1'b0));
    plan.push_back(row_xfer(OP_READ, 8'ha5, 8'd0, 8'h00, AckAll, 1'b0));
    plan.push_back(row_xfer(OP_WRITE, 8'h10, 8'd1, 8'h33, int'(STG_DEV_W), 1'b0));
    plan.push_back(row_word(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, StatDevNack));
    plan.push_back(row_xfer(OP_WRITE, 8'h20, 8'd2, 8'h44, int'(STG_WORD), 1'b0));
    plan.push_back(row_word(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, StatWordNack));
    plan.push_back(row_xfer(OP_READ, 8'h30, 8'd1, 8'h00, int'(STG_DEV_R), 1'b0));
    plan.push_back(row_word(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, StatRdNack));
    plan.push_back(row_xfer(OP_WRITE, 8'h40, 8'hff, 8'hc3, int'(STG_WDATA), 1'b0));
    plan.push_back(row_word(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, StatDataNack));
    plan.push_back(row_cfg(CfgHalfPeriod, 16'd0));
    plan.push_back(row_cfg(CfgDevAddr, 16'd0));
    plan.push_back(row_xfer(OP_WRITE, 8'h00, 8'd3, 8'h00, AckAll, 1'b1));
    plan.push_back(row_xfer(OP_READ, 8'hff, 8'd3, 8'h00, AckAll, 1'b1));
    plan.push_back(row_cfg(CfgHalfPeriod, 16'd2));
    plan.push_back(row_xfer(OP_READ, 8'h80, 8'd1, 8'h00, AckAll, 1'b0));
    plan.push_back(row_word(OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, StatOk));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WORD: begin
          w = '{plan[i].op, plan[i].wa, plan[i].cnt, plan[i].wd, plan[i].sda};
          offer_word(w, 1'b1, idle_word(plan[i].want_stat));
        end
        ROW_XFER: run_transfer(plan[i].op, plan[i].wa, plan[i].cnt, plan[i].wd,
                               plan[i].nack_at, plan[i].noisy, 1'b0);
        default: begin
          drain_bus();
          write_reg(plan[i].cfg_idx, plan[i].cfg_val);
        end
      endcase
    end

    // random transfers, new timing and sometimes a new address every few of them
    xfers = 0;
    while (n_sent < NumItems) begin
      if ($urandom_range(99) < 85) begin
        if (xfers % 4 == 0) begin
          drain_bus();
          case ($urandom_range(4))
            0:       write_reg(CfgHalfPeriod, 16'd0);
            1, 2:    write_reg(CfgHalfPeriod, 16'd1);
            3:       write_reg(CfgHalfPeriod, 16'd2);
            default: write_reg(CfgHalfPeriod, 16'd3);
          endcase
          if ($urandom_range(1)) write_reg(CfgDevAddr, 16'($urandom));
        end
        nack = ($urandom_range(4) == 0) ? int'($urandom_range(int'(STG_WDATA))) : AckAll;
        cnt  = ($urandom_range(9) == 0) ? int'($urandom_range(16, 5)) : int'($urandom_range(4));
        run_transfer($urandom_range(1) ? OP_READ : OP_WRITE, 8'($urandom), 8'(cnt),
                     8'($urandom), nack, 1'($urandom_range(1)), 1'b1);
        xfers++;
      end else begin
        // stray ticks and loads while idle
        repeat ($urandom_range(10, 3)) begin
          w = '{$urandom_range(1) ? OP_LOAD : OP_TICK, 8'($urandom), 8'($urandom),
                8'($urandom), 1'($urandom_range(1))};
          offer_word(w, 1'b0, '0);
        end
      end
    end

    // longest half period: start a write and watch its first ticks
    drain_bus();
    write_reg(CfgHalfPeriod, 16'hffff);
    w = '{OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0};
    offer_word(w, 1'b0, '0);
    repeat (30) begin
      w = '{OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom_range(1))};
      offer_word(w, 1'b0, '0);
    end

    drain_bus();
    repeat (8) @(posedge clk_i);
    if (n_mismatch == 0 && bus_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // check each result word, then pick ready for the next cycle
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    bit      stall;
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[ResW-1:0]);
      if (bus_expect_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result word: %s", show_word(got));
      end else begin
        want = bus_expect_q.pop_front();
        if (got.scl !== want.scl || got.sda_release !== want.sda_release ||
            got.read_data !== want.read_data || got.read_valid !== want.read_valid ||
            got.data_request !== want.data_request || got.busy_res !== want.busy_res ||
            got.done_res !== want.done_res || got.status !== want.status) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch at word %0d\n  expected %s\n  actual   %s",
                     n_taken, show_word(want), show_word(got));
        end
      end
      n_taken++;
    end

    // one long hold-off while the sender keeps offering
    if (hold_left == 0 && !hold_done && s_axis_tvalid && n_taken >= 250) begin
      hold_left = 80;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      stall = 1'b1;
    end else begin
      stall = !(n_taken >= 500 && n_taken < 700) && $urandom_range(99) < 16;
    end
    m_axis_tready <= !stall;
  end

endmodule
